>>> design/qlt_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the q-learning table update block
package qlt_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int ACT_W       = $clog2(NUM_ACTIONS);
  localparam int ADDR_W      = STATE_W + ACT_W;
  localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;

  localparam int MODE_W    = 2;
  localparam int STATE_FW  = 8;
  localparam int ACTION_FW = 3;
  localparam int VAL_W     = 16;
  localparam int RATE_W    = 16;
  localparam int FRAC_W    = 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_LEARN  = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_WRITE  = 2'd2
  } mode_e;

  typedef enum logic [APB_AW-3:0] {
    REG_DISCOUNT = 1'b0,
    REG_TERMINAL = 1'b1
  } reg_e;

  localparam logic [RATE_W-1:0] DISCOUNT_RST = 16'd64880;
  localparam logic [VAL_W-1:0]  TERMINAL_RST = 16'd0;

endpackage

>>> design/qlt_item_if.sv
`timescale 1ns / 1ps
// input item channel of the q-learning table update block
interface qlt_item_if;
  import qlt_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic [STATE_FW-1:0]         state;
  logic [ACTION_FW-1:0]        action;
  logic [STATE_FW-1:0]         next_state;
  logic signed [VAL_W-1:0]     reward;
  logic                        done_req;
  logic [RATE_W-1:0]           learning_rate;
  logic                        explore;
  logic [ACTION_FW-1:0]        random_action;
  logic signed [VAL_W-1:0]     entry_value;

  modport source (
    output valid, mode, state, action, next_state, reward, done_req,
           learning_rate, explore, random_action, entry_value,
    input  ready
  );

  modport sink (
    input  valid, mode, state, action, next_state, reward, done_req,
           learning_rate, explore, random_action, entry_value,
    output ready
  );

endinterface

>>> design/qlt_result_if.sv
`timescale 1ns / 1ps
// result channel of the q-learning table update block
interface qlt_result_if;
  import qlt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACTION_FW-1:0]    chosen_action;
  logic signed [VAL_W-1:0] updated_quality;
  logic                    saturated;

  modport source (
    output valid, chosen_action, updated_quality, saturated,
    input  ready
  );

  modport sink (
    input  valid, chosen_action, updated_quality, saturated,
    output ready
  );

endinterface

>>> design/q_learning_table_update.sv
`timescale 1ns / 1ps
// q-learning table update: quality table memory, sequencer and update datapath
//
//   port      dir  kind      contents
//   item_i    in   valid/rdy mode, indices, reward, rate, explore, entry value
//   result_o  out  valid/rdy chosen action, updated quality, saturated flag
//   apb       in   apb       discount (addr 0), terminal value (addr 4)
//
// one item at a time; every table access goes through the one read port and
// the one write port of the quality memory, one read per cycle.
// mode 0: next-state row scan and update, plus a sweep of that row with done_req;
// mode 1: state row scan when greedy, a read when exploring; modes 2/3: write/read.
// after reset a clearing pass zeroes all DEPTH (2048) table entries; no item
// is taken meanwhile. a result waiting on result_o does not block the next item.
module q_learning_table_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qlt_item_if.sink                     item_i,
  qlt_result_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qlt_pkg::APB_AW-1:0]   paddr,
  input  logic [qlt_pkg::APB_DW-1:0]   pwdata,
  output logic [qlt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import qlt_pkg::*;

  localparam int DP_W  = RATE_W + 1 + VAL_W;
  localparam int RND_W = VAL_W + 2;
  localparam int TD_W  = VAL_W + 4;
  localparam int TP_W  = RATE_W + 1 + TD_W;
  localparam int SD_W  = VAL_W + 1;
  localparam int SP_W  = RATE_W + 1 + SD_W;
  localparam int SAT_W = TD_W + 4;
  localparam int HALF  = 1 << (FRAC_W - 1);

  localparam logic signed [SAT_W-1:0] VMAX =
    {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] VMIN =
    {{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
  localparam logic [ACT_W-1:0]  LAST_ACT = ACT_W'(NUM_ACTIONS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_QREAD,
    S_TD,
    S_UPD,
    S_SWEEP,
    S_SWDRAIN,
    S_WRITE,
    S_READ,
    S_RWAIT,
    S_RESP
  } state_e;

  function automatic logic [VAL_W:0] sat_val(input logic signed [SAT_W-1:0] v);
    logic [VAL_W:0] r;
    if (v > VMAX) begin
      r = {1'b1, VMAX[VAL_W-1:0]};
    end else if (v < VMIN) begin
      r = {1'b1, VMIN[VAL_W-1:0]};
    end else begin
      r = {1'b0, v[VAL_W-1:0]};
    end
    return r;
  endfunction

  // control
  state_e               state_q;
  logic [ACT_W-1:0]     cnt_q;
  logic [ADDR_W-1:0]    clr_cnt_q;
  logic                 rd_vld_q;
  logic                 sw_vld_q;
  logic                 clip_q;
  logic                 out_valid_q;
  logic [ACTION_FW-1:0] out_act_q;
  logic [VAL_W-1:0]     out_val_q;
  logic                 out_clip_q;
  logic [VAL_W-1:0]     res_val_q;
  logic [RATE_W-1:0]    discount_q;
  logic [VAL_W-1:0]     terminal_q;

  // item and datapath
  logic [MODE_W-1:0]       mode_q;
  logic [STATE_W-1:0]      st_q;
  logic [STATE_W-1:0]      nst_q;
  logic [STATE_W-1:0]      scan_row_q;
  logic [ACT_W-1:0]        sel_act_q;
  logic [ACTION_FW-1:0]    chosen_q;
  logic signed [VAL_W-1:0] reward_q;
  logic                    done_q;
  logic [RATE_W-1:0]       alpha_q;
  logic [VAL_W-1:0]        entry_q;
  logic signed [VAL_W-1:0] max_q, max_d;
  logic [ACT_W-1:0]        arg_q, arg_d;
  logic [ACT_W-1:0]        rd_idx_q;
  logic signed [VAL_W-1:0] q_q;
  logic signed [DP_W-1:0]  disc_prod_q, disc_prod_d;
  logic signed [TP_W-1:0]  td_prod_q, td_prod_d;
  logic signed [SP_W-1:0]  sw_prod_q, sw_prod_d;
  logic signed [VAL_W-1:0] sw_e_q;
  logic [ACT_W-1:0]        sw_idx_q;

  // memory
  logic [VAL_W-1:0]        mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_q;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_wa, mem_ra;
  logic [VAL_W-1:0]        mem_wd;

  logic                    item_accept, cfg_write;
  logic                    resp_load;
  logic [ADDR_W-1:0]       sa_addr;
  logic signed [DP_W-1:0]  disc_sum;
  logic signed [RND_W-1:0] disc_rnd;
  logic signed [TD_W-1:0]  td;
  logic signed [TP_W-1:0]  tp_sum;
  logic signed [SAT_W-1:0] upd_sum;
  logic [VAL_W:0]          upd_res;
  logic signed [SD_W-1:0]  sw_diff;
  logic signed [SP_W-1:0]  sw_sum;
  logic signed [SAT_W-1:0] sw_acc;
  logic [VAL_W:0]          sw_res;
  logic                    scanning;

  assign item_accept = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign sa_addr = {st_q, sel_act_q};
  assign scanning = (state_q == S_SCAN) || (state_q == S_SCAN_END);
  assign resp_load = (state_q == S_RESP) && (!out_valid_q || result_o.ready);

  assign result_o.valid           = out_valid_q;
  assign result_o.chosen_action   = out_act_q;
  assign result_o.updated_quality = out_val_q;
  assign result_o.saturated       = out_clip_q;

  always_comb begin
    case (reg_e'(paddr[APB_AW-1:2]))
      REG_DISCOUNT: prdata = APB_DW'(discount_q);
      REG_TERMINAL: prdata = APB_DW'(terminal_q);
      default:      prdata = '0;
    endcase
  end

  // row maximum, lowest index wins ties
  always_comb begin
    max_d = max_q;
    arg_d = arg_q;
    if (rd_vld_q && scanning && (rd_idx_q == '0 || rd_data_q > max_q)) begin
      max_d = rd_data_q;
      arg_d = rd_idx_q;
    end
  end

  // update arithmetic
  always_comb begin
    disc_prod_d = $signed({1'b0, discount_q}) * max_q;
    disc_sum    = disc_prod_q + $signed(DP_W'(HALF));
    disc_rnd    = RND_W'(disc_sum >>> FRAC_W);
    td          = TD_W'(reward_q) + TD_W'(disc_rnd) - TD_W'(rd_data_q);
    td_prod_d   = $signed({1'b0, alpha_q}) * td;
    tp_sum      = td_prod_q + $signed(TP_W'(HALF));
    upd_sum     = SAT_W'(q_q) + SAT_W'(tp_sum >>> FRAC_W);
    upd_res     = sat_val(upd_sum);
    sw_diff     = SD_W'($signed(terminal_q)) - SD_W'(rd_data_q);
    sw_prod_d   = $signed({1'b0, alpha_q}) * sw_diff;
    sw_sum      = sw_prod_q + $signed(SP_W'(HALF));
    sw_acc      = SAT_W'(sw_e_q) + SAT_W'(sw_sum >>> FRAC_W);
    sw_res      = sat_val(sw_acc);
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sa_addr;
    mem_wd = upd_res[VAL_W-1:0];
    mem_re = 1'b0;
    mem_ra = sa_addr;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      S_SCAN: begin
        mem_re = 1'b1;
        mem_ra = {scan_row_q, cnt_q};
      end
      S_QREAD, S_READ: begin
        mem_re = 1'b1;
      end
      S_UPD: begin
        mem_we = 1'b1;
      end
      S_SWEEP: begin
        mem_re = 1'b1;
        mem_ra = {nst_q, cnt_q};
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wd = entry_q;
      end
      default: ;
    endcase
    if (sw_vld_q) begin
      mem_we = 1'b1;
      mem_wa = {nst_q, sw_idx_q};
      mem_wd = sw_res[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      sw_vld_q    <= 1'b0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_act_q   <= '0;
      out_val_q   <= '0;
      out_clip_q  <= 1'b0;
      res_val_q   <= '0;
      discount_q  <= DISCOUNT_RST;
      terminal_q  <= TERMINAL_RST;
    end else begin
      rd_vld_q <= mem_re;
      sw_vld_q <= rd_vld_q && (state_q == S_SWEEP || state_q == S_SWDRAIN);
      if (sw_vld_q) begin
        clip_q <= clip_q | sw_res[VAL_W];
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        case (reg_e'(paddr[APB_AW-1:2]))
          REG_DISCOUNT: discount_q <= pwdata[RATE_W-1:0];
          REG_TERMINAL: terminal_q <= pwdata[VAL_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_accept) begin
            clip_q <= 1'b0;
            cnt_q  <= '0;
            case (item_i.mode)
              MODE_LEARN:  state_q <= S_SCAN;
              MODE_SELECT: state_q <= item_i.explore ? S_READ : S_SCAN;
              MODE_WRITE:  state_q <= S_WRITE;
              default:     state_q <= S_READ;
            endcase
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_ACT) begin
            state_q <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          if (mode_q == MODE_LEARN) begin
            state_q <= S_QREAD;
          end else begin
            res_val_q <= max_d;
            state_q   <= S_RESP;
          end
        end
        S_QREAD: state_q <= S_TD;
        S_TD:    state_q <= S_UPD;
        S_UPD: begin
          clip_q    <= upd_res[VAL_W];
          res_val_q <= upd_res[VAL_W-1:0];
          cnt_q     <= '0;
          state_q   <= done_q ? S_SWEEP : S_RESP;
        end
        S_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_ACT) begin
            state_q <= S_SWDRAIN;
          end
        end
        S_SWDRAIN: begin
          if (!rd_vld_q && !sw_vld_q) begin
            state_q <= S_READ;
          end
        end
        S_WRITE: begin
          res_val_q <= entry_q;
          state_q   <= S_RESP;
        end
        S_READ:  state_q <= S_RWAIT;
        S_RWAIT: begin
          res_val_q <= rd_data_q;
          state_q   <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            out_act_q   <= chosen_q;
            out_val_q   <= res_val_q;
            out_clip_q  <= clip_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      mode_q   <= item_i.mode;
      st_q     <= STATE_W'(item_i.state);
      nst_q    <= STATE_W'(item_i.next_state);
      reward_q <= item_i.reward;
      done_q   <= item_i.done_req;
      alpha_q  <= item_i.learning_rate;
      entry_q  <= item_i.entry_value;
      scan_row_q <= (item_i.mode == MODE_LEARN) ? STATE_W'(item_i.next_state)
                                                : STATE_W'(item_i.state);
      if (item_i.mode == MODE_SELECT && item_i.explore) begin
        sel_act_q <= ACT_W'(item_i.random_action);
        chosen_q  <= ACTION_FW'(ACT_W'(item_i.random_action));
      end else begin
        sel_act_q <= ACT_W'(item_i.action);
        chosen_q  <= item_i.action;
      end
    end else if (state_q == S_SCAN_END && mode_q == MODE_SELECT) begin
      chosen_q <= ACTION_FW'(arg_d);
    end
    max_q       <= max_d;
    arg_q       <= arg_d;
    rd_idx_q    <= mem_ra[ACT_W-1:0];
    disc_prod_q <= disc_prod_d;
    td_prod_q   <= td_prod_d;
    sw_prod_q   <= sw_prod_d;
    sw_e_q      <= rd_data_q;
    sw_idx_q    <= rd_idx_q;
    if (state_q == S_TD) begin
      q_q <= rd_data_q;
    end
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("table written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept |=> state_q != S_IDLE)
    else $error("accepted item did not start");

  a_sweep_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_vld_q |-> (state_q == S_SWEEP || state_q == S_SWDRAIN))
    else $error("terminal row write outside sweep");

  a_read_data_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(mem_re))
    else $error("read data valid without a read");

endmodule
